[src/fmrp_pkg.sv]
`default_nettype none
package fmrp_pkg;

    localparam int RATE_W   = 9;
    localparam int IN_TDW   = 16;
    localparam int OUT_TDW  = 88;
    localparam int DIV_NW   = 24;
    localparam int DIV_DW   = 20;
    localparam int OSR_W    = 12;
    localparam int PRE_W    = 27;
    localparam int PROD_W   = 55;
    localparam int RCP_W    = 28;
    localparam int RCP_SH   = 36;

    // floor(x/375) = (x * RCP_375) >> RCP_SH, exact for x < 2^27
    localparam logic [RCP_W-1:0] RCP_375 = 28'd183251938;

    localparam logic [7:0] MOD_LOW   = 8'h4C;
    localparam logic [7:0] MOD_HIGH  = 8'h0C;
    localparam logic [7:0] DEV_LOW   = 8'd24;
    localparam logic [7:0] DEV_HIGH  = 8'd240;
    localparam logic [7:0] KHZ_LOW   = 8'd15;
    localparam logic [7:0] KHZ_HIGH  = 8'd150;
    localparam logic [7:0] IFC_NONE  = 8'hFF;
    localparam logic [10:0] GAIN_MAX = 11'h7FF;
    localparam logic [DIV_NW-1:0] GAIN_SAT_Q = 24'd2045;

    localparam int FLT_N = 8;
    localparam logic [12:0] FLT_BW [FLT_N] = '{
        13'd322, 13'd3355, 13'd3618, 13'd4202, 13'd4684, 13'd5188, 13'd5770, 13'd6207
    };
    localparam logic [7:0] FLT_CODE [FLT_N] = '{
        8'h26, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C, 8'h8D, 8'h8E
    };

    typedef struct packed {
        logic              acc;
        logic [7:0]        mod_mode;
        logic [7:0]        dev_code;
        logic [15:0]       dr_word;
        logic [7:0]        ifc;
        logic [19:0]       nco;
        logic [OSR_W-1:0]  osr;
        logic              dev15;
        logic [RATE_W-1:0] rate;
    } t_side;

    function automatic logic [7:0] flt_pick(input logic [12:0] need);
        logic [7:0] code;
        logic       found;
        code  = IFC_NONE;
        found = 1'b0;
        for (int i = 0; i < FLT_N; i++) begin
            if (!found && FLT_BW[i] >= need) begin
                code  = FLT_CODE[i];
                found = 1'b1;
            end
        end
        return code;
    endfunction

endpackage
`default_nettype wire

[src/fmrp_front.sv]
`default_nettype none
module fmrp_front
    import fmrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [RATE_W-1:0] i_rate,
    output logic                   o_valid,
    output logic [DIV_NW-1:0]      o_num,
    output logic [DIV_DW-1:0]      o_den,
    output t_side                  o_side
);

    logic              acc, lt30, dev15, b;
    logic [2:0]        e;
    logic [9:0]        s;
    logic [12:0]       need;
    logic [7:0]        ifc;
    logic [10:0]       nco_base;
    logic [PRE_W-1:0]  x_nco, dr, y1, y3;
    t_side             side_a;

    logic              r_va, r_vb;
    t_side             r_side_a, r_side_b;
    logic [PRE_W-1:0]  r_x, r_y;
    logic [DIV_NW-1:0] r_num_a, r_num_b;
    logic [DIV_DW-1:0] r_den_a, r_den_b;
    logic [PROD_W-1:0] r_pdr, r_pnco;

    always_comb begin
        acc   = (i_rate != '0) && (i_rate <= 9'd256);
        lt30  = i_rate < 9'd30;
        dev15 = i_rate <= 9'd10;
        s     = dev15 ? (10'd30 + 10'(i_rate)) : (10'd300 + 10'(i_rate));
        need  = (13'(s) << 3) + (13'(s) << 1);
        ifc   = flt_pick(need);
        b     = ifc[7];
        e     = ifc[6:4];
        // only (b=1,e=0) and (b=0,e=2) occur for accepted rates
        nco_base = b ? 11'(i_rate) : (11'(i_rate) << 1) + 11'(i_rate);
        x_nco    = (PRE_W'(nco_base) << (5'(e) + 5'd18)) + 27'd374;
        dr       = lt30 ? (PRE_W'(i_rate) << 18) : (PRE_W'(i_rate) << 13);
        y1       = dr + 27'd62;
        y3       = (y1 << 1) + y1;
        side_a          = '0;
        side_a.acc      = acc;
        side_a.mod_mode = lt30 ? MOD_LOW : MOD_HIGH;
        side_a.dev_code = dev15 ? DEV_LOW : DEV_HIGH;
        side_a.ifc      = ifc;
        side_a.dev15    = dev15;
        side_a.rate     = i_rate;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side_a <= side_a;
            r_x      <= x_nco;
            r_y      <= y3;
            r_num_a  <= (b ? 24'd24000 : 24'd8000) + DIV_NW'(16'(i_rate) << e);
            r_den_a  <= DIV_DW'(17'(i_rate) << (4'(e) + 4'd1));
            r_side_b <= r_side_a;
            r_num_b  <= r_num_a;
            r_den_b  <= r_den_a;
            r_pdr    <= {28'b0, r_y} * {27'b0, RCP_375};
            r_pnco   <= {28'b0, r_x} * {27'b0, RCP_375};
        end
    end

    always_comb begin
        o_side         = r_side_b;
        o_side.dr_word = 16'(r_pdr >> RCP_SH);
        o_side.nco     = 20'(r_pnco >> RCP_SH);
    end

    assign o_valid = r_vb;
    assign o_num   = r_num_b;
    assign o_den   = r_den_b;

endmodule
`default_nettype wire

[src/fmrp_div.sv]
`default_nettype none
module fmrp_div
    import fmrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DIV_NW-1:0] i_num,
    input  wire logic [DIV_DW-1:0] i_den,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [DIV_NW-1:0]      o_quo,
    output t_side                  o_side
);

    logic              r_v   [DIV_NW];
    logic [DIV_DW-1:0] r_rem [DIV_NW];
    logic [DIV_NW-1:0] r_num [DIV_NW];
    logic [DIV_NW-1:0] r_q   [DIV_NW];
    logic [DIV_DW-1:0] r_den [DIV_NW];
    t_side             r_sd  [DIV_NW];

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < DIV_NW; k++) begin : g_st
        logic              w_pv, w_ge;
        logic [DIV_DW-1:0] w_prem, w_den, n_rem;
        logic [DIV_NW-1:0] w_pnum, w_pq;
        logic [DIV_DW:0]   w_t;
        t_side             w_psd;

        if (k == 0) begin : g_first
            assign w_pv   = i_valid;
            assign w_prem = '0;
            assign w_pnum = i_num;
            assign w_pq   = '0;
            assign w_den  = i_den;
            assign w_psd  = i_side;
        end else begin : g_next
            assign w_pv   = r_v[k-1];
            assign w_prem = r_rem[k-1];
            assign w_pnum = r_num[k-1];
            assign w_pq   = r_q[k-1];
            assign w_den  = r_den[k-1];
            assign w_psd  = r_sd[k-1];
        end

        assign w_t   = {w_prem, w_pnum[DIV_NW-1]};
        assign w_ge  = w_t >= {1'b0, w_den};
        assign n_rem = w_ge ? DIV_DW'(w_t - {1'b0, w_den}) : DIV_DW'(w_t);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_num[k] <= w_pnum << 1;
                r_q[k]   <= {w_pq[DIV_NW-2:0], w_ge};
                r_den[k] <= w_den;
                r_sd[k]  <= w_psd;
            end
        end
    end

    assign o_valid = r_v[DIV_NW-1];
    assign o_quo   = r_q[DIV_NW-1];
    assign o_side  = r_sd[DIV_NW-1];

endmodule
`default_nettype wire

[src/fmrp_gain.sv]
`default_nettype none
module fmrp_gain
    import fmrp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [DIV_NW-1:0] i_quo,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [DIV_NW-1:0]      o_num,
    output logic [DIV_DW-1:0]      o_den,
    output t_side                  o_side
);

    logic              r_v;
    logic [DIV_NW-1:0] r_num;
    logic [DIV_DW-1:0] r_den;
    t_side             r_side;
    t_side             side_n;
    logic [7:0]        dev_khz;

    always_comb begin
        side_n     = i_side;
        side_n.osr = i_quo[OSR_W-1:0];
        dev_khz    = i_side.dev15 ? KHZ_LOW : KHZ_HIGH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= side_n;
            r_num  <= (DIV_NW'(i_side.rate) << 16) - DIV_NW'(i_side.rate);
            r_den  <= {8'b0, i_quo[OSR_W-1:0]} * {12'b0, dev_khz};
        end
    end

    assign o_valid = r_v;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule
`default_nettype wire

[src/fsk_modem_rate_parameter_calc.sv]
// Pipeline from input transaction to o_m_tvalid: decode, multiply,
// two 24-stage restoring dividers, gain multiply, output register.
// Throughput: one transaction per cycle while o_s_tready is high; a 2-entry
// output register/skid absorbs o_m_tready stalls and halts the pipeline when full.
// Reset: synchronous active-low i_rst_n clears all valid bits; no data reset.
`default_nettype none
module fsk_modem_rate_parameter_calc
    import fmrp_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [IN_TDW-1:0]  i_s_tdata,   // rate_kbps[8:0]
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [OUT_TDW-1:0]      o_m_tdata,   // modulation_mode, deviation_code,
                                                 // data_rate_word, if_filter_code,
                                                 // oversampling_ratio, nco_offset,
                                                 // recovery_gain
    output logic                    o_m_tuser    // accepted
);

    logic              en;
    logic              f_v, d1_v, g_v, d2_v;
    logic [DIV_NW-1:0] f_num, d1_q, g_num, d2_q;
    logic [DIV_DW-1:0] f_den, g_den;
    t_side             f_sd, d1_sd, g_sd, d2_sd;

    logic [10:0]       gain;
    logic [OUT_TDW-1:0] fin_data;
    logic              fin_acc;

    logic               r_out_v, r_skid_v, r_out_acc, r_skid_acc;
    logic [OUT_TDW-1:0] r_out_d, r_skid_d;

    assign en         = !r_skid_v;
    assign o_s_tready = en;

    fmrp_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_s_tvalid),
        .i_rate (i_s_tdata[RATE_W-1:0]),
        .o_valid(f_v),
        .o_num  (f_num),
        .o_den  (f_den),
        .o_side (f_sd)
    );

    fmrp_div u_div_osr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(f_v),
        .i_num  (f_num),
        .i_den  (f_den),
        .i_side (f_sd),
        .o_valid(d1_v),
        .o_quo  (d1_q),
        .o_side (d1_sd)
    );

    fmrp_gain u_gain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(d1_v),
        .i_quo  (d1_q),
        .i_side (d1_sd),
        .o_valid(g_v),
        .o_num  (g_num),
        .o_den  (g_den),
        .o_side (g_sd)
    );

    fmrp_div u_div_gain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(g_v),
        .i_num  (g_num),
        .i_den  (g_den),
        .i_side (g_sd),
        .o_valid(d2_v),
        .o_quo  (d2_q),
        .o_side (d2_sd)
    );

    always_comb begin
        gain    = (d2_q >= GAIN_SAT_Q) ? GAIN_MAX : 11'(d2_q) + 11'd2;
        fin_acc = d2_sd.acc;
        if (d2_sd.acc) begin
            fin_data = {6'b0, gain, d2_sd.nco, d2_sd.osr[10:0], d2_sd.ifc,
                        d2_sd.dr_word, d2_sd.dev_code, d2_sd.mod_mode};
        end else begin
            fin_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_m_tready) begin
            r_out_v  <= r_skid_v || d2_v;
            r_skid_v <= 1'b0;
        end else if (d2_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_m_tready) begin
            r_out_d   <= r_skid_v ? r_skid_d : fin_data;
            r_out_acc <= r_skid_v ? r_skid_acc : fin_acc;
        end else if (en && d2_v) begin
            r_skid_d   <= fin_data;
            r_skid_acc <= fin_acc;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_d;
    assign o_m_tuser  = r_out_acc;

endmodule
`default_nettype wire

[src/fmrp_chk.sv]
`default_nettype none
module fmrp_chk
    import fmrp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_m_tvalid,
    input wire logic               i_m_tready,
    input wire logic [OUT_TDW-1:0] i_m_tdata,
    input wire logic               i_m_tuser
);

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser |-> i_m_tdata == '0)
        else $error("rejected rate with nonzero settings");

    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |->
            (i_m_tdata[7:0] == MOD_LOW || i_m_tdata[7:0] == MOD_HIGH) &&
            (i_m_tdata[15:8] == DEV_LOW || i_m_tdata[15:8] == DEV_HIGH))
        else $error("bad mode or deviation code");

    a_gain_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser |-> i_m_tdata[81:71] >= 11'd2)
        else $error("recovery gain below floor");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("output changed while stalled");

endmodule

bind fsk_modem_rate_parameter_calc fmrp_chk u_fmrp_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .i_m_tdata (o_m_tdata),
    .i_m_tuser (o_m_tuser)
);
`default_nettype wire
